@@ rtl/pbtds_pkg.sv @@
package pbtds_pkg;

   localparam int TIME_W = 31;
   localparam int DUR_W  = 16;
   localparam int SIZE_W = 7;

   typedef logic [TIME_W-1:0] time_type;
   typedef logic [DUR_W-1:0]  dur_type;
   typedef logic [SIZE_W-1:0] size_type;

   localparam time_type TIME_MAX   = {TIME_W{1'b1}};
   localparam size_type SIZE_RESET = 7'd64;

endpackage

@@ rtl/packet_buffer_tail_drop_scheduler.sv @@
// channel   direction  beat contents                          handshake
// req       in         arrival, duration                      req_valid / req_ready
// rsp       out        dropped, start                         rsp_valid / rsp_ready
// csr       in         buffer_size                            csr_valid / csr_ready
//
// a packet is accepted in idle and passes read and compare for each finish time it
// retires and for a head entry tested that stays in the fifo, then is decided.
// one shared comparator serves the retire test and the start-time choice.
// reset is synchronous and empties the fifo; buffer_size returns to 64.
// req_ready is low while a packet is in work; a result waiting in the output
// register does not block the next packet until that packet's result is due.
module packet_buffer_tail_drop_scheduler
   import pbtds_pkg::*;
#(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  time_type req_arrival,
   input  dur_type  req_duration,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output logic     rsp_dropped,
   output time_type rsp_start,
   input  logic     csr_valid,
   output logic     csr_ready,
   input  size_type csr_buffer_size
);

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int CMP_W = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RD   = 2'd1;
   localparam logic [1:0] ST_CMP  = 2'd2;
   localparam logic [1:0] ST_DEC  = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0] occ_ff, occ_in;
   time_type         last_finish_ff, last_finish_in;
   size_type         size_ff, size_in;
   time_type         arrival_ff, arrival_in;
   dur_type          dur_ff, dur_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             dropped_ff, dropped_in;
   time_type         start_ff, start_in;

   time_type         finish_mem [QUEUE_DEPTH];
   time_type         rd_data_ff;

   time_type         cmp_a;
   logic             later;
   logic             full;
   logic             out_free;
   logic             push;
   time_type         start_sel;
   logic [TIME_W:0]  finish_sum;
   time_type         finish;
   logic [IDX_W-1:0] head_next;
   logic [IDX_W-1:0] tail_next;

   // shared comparator: fifo head during retire, last finish when deciding
   assign cmp_a = (state_ff == ST_CMP) ? rd_data_ff : last_finish_ff;
   assign later = cmp_a > arrival_ff;

   assign full = (CMP_W'(occ_ff) >= CMP_W'(size_ff)) || (occ_ff == CNT_W'(QUEUE_DEPTH));
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign push = (state_ff == ST_DEC) && out_free && !full;

   assign start_sel  = ((occ_ff != '0) && later) ? last_finish_ff : arrival_ff;
   assign finish_sum = {1'b0, start_sel} + {{(TIME_W + 1 - DUR_W){1'b0}}, dur_ff};
   assign finish     = finish_sum[TIME_W] ? TIME_MAX : finish_sum[TIME_W-1:0];

   assign head_next = (head_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign tail_next = (tail_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;

   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      occ_in         = occ_ff;
      last_finish_in = last_finish_ff;
      size_in        = size_ff;
      arrival_in     = arrival_ff;
      dur_in         = dur_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      dropped_in     = dropped_ff;
      start_in       = start_ff;

      if (csr_valid) begin
         size_in = csr_buffer_size;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               arrival_in = req_arrival;
               dur_in     = req_duration;
               state_in   = (occ_ff != '0) ? ST_RD : ST_DEC;
            end
         end
         ST_RD: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (!later) begin
               // head finished by arrival: retire it and look at the next one
               head_in  = head_next;
               occ_in   = occ_ff - 1'b1;
               state_in = (occ_ff == CNT_W'(1)) ? ST_DEC : ST_RD;
            end else begin
               state_in = ST_DEC;
            end
         end
         ST_DEC: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               dropped_in   = full;
               start_in     = full ? '0 : start_sel;
               if (!full) begin
                  tail_in        = tail_next;
                  occ_in         = occ_ff + 1'b1;
                  last_finish_in = finish;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         head_ff        <= '0;
         tail_ff        <= '0;
         occ_ff         <= '0;
         last_finish_ff <= '0;
         size_ff        <= SIZE_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         head_ff        <= head_in;
         tail_ff        <= tail_in;
         occ_ff         <= occ_in;
         last_finish_ff <= last_finish_in;
         size_ff        <= size_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      arrival_ff <= arrival_in;
      dur_ff     <= dur_in;
      dropped_ff <= dropped_in;
      start_ff   <= start_in;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         finish_mem[tail_ff] <= finish;
      end
      rd_data_ff <= finish_mem[head_ff];
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_dropped = dropped_ff;
   assign rsp_start   = start_ff;

endmodule

@@ rtl/pbtds_checker.sv @@
module pbtds_checker
   import pbtds_pkg::*;
(
   input logic     clock,
   input logic     reset,
   input logic     req_valid,
   input logic     req_ready,
   input logic     rsp_valid,
   input logic     rsp_ready,
   input logic     rsp_dropped,
   input time_type rsp_start
);

   // a dropped packet never reports a start time
   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dropped |-> rsp_start == '0)
      else $error("dropped beat with nonzero start");

   // one packet in work at a time
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready held high after a req beat");

   // a result is registered in the decide state: no rsp beat in the cycle after acceptance
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("rsp beat appeared one cycle after req beat");

   // pending result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_dropped)
         && $stable(rsp_start))
      else $error("rsp beat changed while stalled");

endmodule

bind packet_buffer_tail_drop_scheduler pbtds_checker u_pbtds_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_dropped (rsp_dropped),
   .rsp_start   (rsp_start)
);

@@ tb/packet_buffer_tail_drop_scheduler_tb.sv @@
module packet_buffer_tail_drop_scheduler_tb
   import pbtds_pkg::*;
();

   typedef struct {
      time_type arrival;
      dur_type  duration;
   } packet_type;

   typedef struct {
      logic     dropped;
      time_type start;
   } outcome_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_ready;
   time_type req_arrival = '0;
   dur_type  req_duration = '0;
   logic     rsp_valid;
   logic     rsp_ready = 1'b0;
   logic     rsp_dropped;
   time_type rsp_start;
   logic     csr_valid = 1'b0;
   logic     csr_ready;
   size_type csr_buffer_size = '0;

   packet_buffer_tail_drop_scheduler dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_arrival     (req_arrival),
      .req_duration    (req_duration),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_dropped     (rsp_dropped),
      .rsp_start       (rsp_start),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_buffer_size (csr_buffer_size)
   );

   always #6 clock = ~clock;

   // scheduler shadow state
   time_type   sched_fifo [64];
   logic [5:0] sched_head = '0;
   int         sched_count = 0;
   time_type   sched_last = '0;
   size_type   sched_size = SIZE_RESET;

   packet_type  pkt_q [$];
   outcome_type due_q [$];
   int          errors = 0;

   int          burst_left = 0;
   int          gap_left = 0;
   logic [15:0] rdy_pat = 16'hFFFF;
   int          rdy_pos = 0;
   packet_type  next_pkt;
   outcome_type next_out;
   outcome_type seen_out;

   function automatic outcome_type schedule_packet(input time_type arr, input dur_type dur);
      outcome_type o;
      int          cap;
      logic [31:0] fin;
      logic [5:0]  tail;
      cap = (sched_size > 7'd64) ? 64 : int'(sched_size);
      // retire everything finished by this arrival
      while (sched_count != 0 && sched_fifo[sched_head] <= arr) begin
         sched_head  = sched_head + 6'd1;
         sched_count = sched_count - 1;
      end
      if (sched_count >= cap) begin
         o.dropped = 1'b1;
         o.start   = '0;
         return o;
      end
      o.dropped = 1'b0;
      o.start   = arr;
      if (sched_count != 0 && sched_last > arr) o.start = sched_last;
      fin = {1'b0, o.start} + {16'd0, dur};
      if (fin > {1'b0, TIME_MAX}) fin = {1'b0, TIME_MAX};
      tail = sched_head + sched_count[5:0];
      sched_fifo[tail] = fin[30:0];
      sched_count = sched_count + 1;
      sched_last  = fin[30:0];
      return o;
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      errors = errors + 1;
   endtask

   // driver: bursts of beats with random gaps, expectation formed when a beat is presented
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_ready)) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pkt_q.size() != 0) begin
            next_pkt = pkt_q.pop_front();
            next_out = schedule_packet(next_pkt.arrival, next_pkt.duration);
            due_q.insert(due_q.size(), next_out);
            req_valid    <= 1'b1;
            req_arrival  <= next_pkt.arrival;
            req_duration <= next_pkt.duration;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 12);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: checks result beats and stalls the receiver on a rotating pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_q.size() == 0) begin
               report_mismatch("result beat with nothing expected");
            end else begin
               seen_out = due_q.pop_front();
               if (rsp_dropped !== seen_out.dropped)
                  report_mismatch($sformatf("dropped %b, expected %b",
                                            rsp_dropped, seen_out.dropped));
               if (rsp_start !== seen_out.start)
                  report_mismatch($sformatf("start %0d, expected %0d",
                                            rsp_start, seen_out.start));
            end
         end
         rsp_ready <= rdy_pat[rdy_pos];
         if (rdy_pos == 15) begin
            rdy_pos <= 0;
            case ($urandom_range(0, 3))
               0: rdy_pat <= 16'hFFFF;
               1: rdy_pat <= 16'($urandom() & $urandom());
               default: rdy_pat <= 16'($urandom());
            endcase
         end else begin
            rdy_pos <= rdy_pos + 1;
         end
      end
   end

   task automatic add_pkt(input time_type arr, input dur_type dur);
      packet_type p;
      p.arrival  = arr;
      p.duration = dur;
      pkt_q.insert(pkt_q.size(), p);
   endtask

   task automatic wait_idle();
      while (pkt_q.size() != 0 || req_valid || due_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_size(input size_type v);
      @(posedge clock);
      csr_buffer_size <= v;
      csr_valid       <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid  <= 1'b0;
      sched_size = v;
      @(negedge clock);
   endtask

   // each phase starts from an empty buffer: zero capacity plus a max arrival retires all
   task automatic run_phase(input size_type size, input int count, input int dmax,
                            input int pmax, input longint base, input bit noisy);
      longint  t;
      longint  a;
      dur_type d;
      write_size('0);
      add_pkt(TIME_MAX, dur_type'($urandom()));
      wait_idle();
      write_size(size);
      t = base;
      for (int i = 0; i < count; i++) begin
         t = t + $urandom_range(0, dmax);
         if (t > longint'(TIME_MAX)) t = TIME_MAX;
         a = t;
         if (noisy && $urandom_range(0, 15) == 0) begin
            a = t - $urandom_range(0, 1000);
            if (a < 0) a = 0;
         end
         d = ($urandom_range(0, 31) == 0) ? dur_type'($urandom())
                                          : dur_type'($urandom_range(0, pmax));
         add_pkt(time_type'(a), d);
      end
      wait_idle();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset capacity: zero durations, same-time retire, long jobs, saturation
      add_pkt('0, '0);
      add_pkt('0, '0);
      add_pkt(31'd10, 16'hFFFF);
      add_pkt(31'd11, 16'd5);
      add_pkt(TIME_MAX - 31'd10, 16'hFFFF);
      add_pkt(TIME_MAX - 31'd5, 16'd100);
      add_pkt(TIME_MAX, 16'd1);
      add_pkt(31'd100, 16'd50);
      wait_idle();

      // zero capacity drops everything
      write_size('0);
      add_pkt(TIME_MAX, 16'hFFFF);
      add_pkt('0, '0);
      add_pkt(31'h2AAAAAAA, 16'h5555);
      wait_idle();

      // single slot
      write_size(7'd1);
      add_pkt('0, 16'd10);
      add_pkt(31'd5, 16'd10);
      add_pkt(31'd10, 16'd1);
      add_pkt(31'd11, '0);
      add_pkt(31'h55555555, 16'hAAAA);
      wait_idle();

      run_phase(7'd127, 100, 20, 100, $urandom_range(0, 1 << 20), 1'b0);
      run_phase(7'd64, 70, 50, 80, $urandom_range(0, 1 << 20), 1'b1);
      run_phase(7'd3, 50, 60, 100, $urandom_range(0, 1 << 20), 1'b1);
      run_phase(7'd1, 40, 100, 100, $urandom_range(0, 1 << 20), 1'b1);
      run_phase(size_type'($urandom()), 50, 300, 65535, $urandom_range(0, 1 << 20), 1'b1);
      run_phase(size_type'($urandom_range(4, 64)), 40, 20000, 65535,
                longint'(TIME_MAX) - 1000000, 1'b1);
      run_phase(7'd0, 20, 100, 65535, $urandom_range(0, 1 << 20), 1'b1);

      if (errors == 0) begin
         $display("packet_buffer_tail_drop_scheduler verification clean");
      end else begin
         $display("packet_buffer_tail_drop_scheduler verification failed");
      end
      $finish;
   end

   initial begin
      #(12 * 600000);
      $display("packet_buffer_tail_drop_scheduler verification failed");
      $finish;
   end

endmodule
